// ===== hdl/lswsum_pkg.sv =====
// Shared constants, command and status types for the longest-subarray-with-sum block.
package lswsum_pkg;

    localparam int SUM_BITS           = 27;
    localparam int EPOCH_BITS         = 8;
    localparam int DEF_MAX_LEN        = 1024;
    localparam int DEF_VALUE_BITS     = 16;
    localparam int DEF_TABLE_SLOTS    = 2048;

    typedef struct packed {
        logic accept;
        logic add;
        logic set_ovf;
        logic set_best_full;
        logic mod_start;
        logic key_diff;
        logic probe_init;
        logic probe_next;
        logic take_cand;
        logic mem_wr;
        logic pos_inc;
        logic load_out;
        logic clear_run;
        logic clr_wr;
    } lswsum_cmd_t;

    typedef struct packed {
        logic cap_full;
        logic eq_target;
        logic diff_ok;
        logic mod_done;
        logic slot_hit;
        logic slot_free;
        logic probe_last;
        logic last_item;
        logic out_free;
        logic epoch_wrap;
        logic clr_last;
    } lswsum_sts_t;

endpackage

// ===== hdl/lswsum_ram.sv =====
// Generic single-port RAM with registered read data.
module lswsum_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/lswsum_mod.sv =====
// Home slot unit: key pattern modulo the table size, mask or reciprocal multiply.
module lswsum_mod #(
    parameter int TABLE_SLOTS = lswsum_pkg::DEF_TABLE_SLOTS,
    localparam int SLOT_W = $clog2(TABLE_SLOTS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lswsum_pkg::SUM_BITS-1:0] key,
    output logic                          done,
    output logic [SLOT_W-1:0]             rem
);

    localparam int KW = lswsum_pkg::SUM_BITS;

    logic              done_reg;
    logic [SLOT_W-1:0] rem_reg;

    assign done = done_reg;
    assign rem  = rem_reg;

    if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0)
    begin : g_mask
        // power of two: the remainder is the low bits
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                done_reg <= 1'b0;
            end
            else
            begin
                done_reg <= start;
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                rem_reg <= key[SLOT_W-1:0];
            end
        end
    end
    else
    begin : g_recip
        // quotient = (key * ceil(2^SH / slots)) >> SH is exact for every key pattern;
        // then remainder = key - quotient * slots
        localparam int SH  = KW + SLOT_W;
        localparam int QW  = KW + 1 - SLOT_W;
        localparam longint MUL =
            ((longint'(1) << SH) + longint'(TABLE_SLOTS) - 1) / longint'(TABLE_SLOTS);
        localparam logic [KW:0]       MUL_C = (KW + 1)'(MUL);
        localparam logic [SLOT_W-1:0] DIV_C = SLOT_W'(TABLE_SLOTS);

        logic [KW-1:0] key_reg;
        logic [QW-1:0] quo_reg;
        logic          s1_reg;
        logic          s2_reg;
        logic [2*KW:0] prod;
        logic [KW:0]   back;
        logic [KW-1:0] diff;

        assign prod = key_reg * MUL_C;
        assign back = quo_reg * DIV_C;
        assign diff = key_reg - back[KW-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                s1_reg   <= 1'b0;
                s2_reg   <= 1'b0;
                done_reg <= 1'b0;
            end
            else
            begin
                s1_reg   <= start;
                s2_reg   <= s1_reg;
                done_reg <= s2_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                key_reg <= key;
            end
            if (s1_reg)
            begin
                quo_reg <= prod[2*KW:SH];
            end
            if (s2_reg)
            begin
                rem_reg <= diff[SLOT_W-1:0];
            end
        end
    end

endmodule

// ===== hdl/lswsum_dp.sv =====
// Datapath: prefix sum, position, best length, hash table probing and result register.
module lswsum_dp #(
    parameter int MAX_LEN     = lswsum_pkg::DEF_MAX_LEN,
    parameter int VALUE_BITS  = lswsum_pkg::DEF_VALUE_BITS,
    parameter int TABLE_SLOTS = lswsum_pkg::DEF_TABLE_SLOTS,
    localparam int LEN_W = $clog2(MAX_LEN + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lswsum_pkg::SUM_BITS-1:0] cfg_wr_data,
    input  logic [VALUE_BITS-1:0]           elem_in,
    input  logic                            last_in,
    input  logic                            m_tready,
    input  lswsum_pkg::lswsum_cmd_t         cmd,
    output lswsum_pkg::lswsum_sts_t         sts,
    output logic                            out_valid,
    output logic [LEN_W-1:0]                out_len,
    output logic                            out_ovf
);

    localparam int SW     = lswsum_pkg::SUM_BITS;
    localparam int EW     = lswsum_pkg::EPOCH_BITS;
    localparam int POS_W  = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int WORD_W = 1 + EW + SW + POS_W;

    logic signed [VALUE_BITS-1:0] elem_reg;
    logic                         last_reg;
    logic signed [SW-1:0]         target_reg;
    logic signed [SW-1:0]         total_reg;
    logic [LEN_W-1:0]             pos_reg;
    logic [LEN_W-1:0]             best_reg;
    logic                         ovf_reg;
    logic [SW-1:0]                key_reg;
    logic [SLOT_W-1:0]            idx_reg;
    logic [SLOT_W-1:0]            cnt_reg;
    logic [EW-1:0]                epoch_reg;
    logic [SLOT_W-1:0]            clr_cnt_reg;
    logic                         out_valid_reg;
    logic [LEN_W-1:0]             out_len_reg;
    logic                         out_ovf_reg;

    logic signed [SW-1:0] elem_ext;
    logic signed [SW:0]   diff_full;
    logic [SW-1:0]        key_in;
    logic                 mod_done;
    logic [SLOT_W-1:0]    home;
    logic [SLOT_W-1:0]    mem_addr;
    logic                 mem_we;
    logic [WORD_W-1:0]    mem_wdata;
    logic [WORD_W-1:0]    mem_rdata;
    logic                 rd_ok;
    logic [EW-1:0]        rd_epoch;
    logic [SW-1:0]        rd_key;
    logic [POS_W-1:0]     rd_pos;
    logic                 slot_live;
    logic [LEN_W-1:0]     cand;

    assign elem_ext  = SW'(elem_reg);
    assign diff_full = (SW + 1)'(total_reg) - (SW + 1)'(target_reg);
    assign key_in    = cmd.key_diff ? diff_full[SW-1:0] : total_reg;

    lswsum_mod #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mod_start),
        .key   (key_in),
        .done  (mod_done),
        .rem   (home)
    );

    // table word: live mark, epoch, key, first position
    assign mem_addr  = cmd.clr_wr ? clr_cnt_reg : idx_reg;
    assign mem_we    = cmd.clr_wr | cmd.mem_wr;
    assign mem_wdata = cmd.clr_wr ? '0 : {1'b1, epoch_reg, key_reg, pos_reg[POS_W-1:0]};

    lswsum_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign {rd_ok, rd_epoch, rd_key, rd_pos} = mem_rdata;
    assign slot_live = rd_ok && (rd_epoch == epoch_reg);
    assign cand      = pos_reg - LEN_W'(rd_pos);

    always_comb
    begin
        sts.cap_full   = (pos_reg == LEN_W'(MAX_LEN));
        sts.eq_target  = (total_reg == target_reg);
        sts.diff_ok    = (diff_full[SW] == diff_full[SW-1]);
        sts.mod_done   = mod_done;
        sts.slot_hit   = slot_live && (rd_key == key_reg);
        sts.slot_free  = !slot_live;
        sts.probe_last = (cnt_reg == SLOT_W'(TABLE_SLOTS - 1));
        sts.last_item  = last_reg;
        sts.out_free   = !out_valid_reg || m_tready;
        sts.epoch_wrap = &epoch_reg;
        sts.clr_last   = (clr_cnt_reg == SLOT_W'(TABLE_SLOTS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            total_reg     <= '0;
            pos_reg       <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            epoch_reg     <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
            if (cmd.accept)
            begin
                last_reg <= last_in;
            end
            if (cmd.add)
            begin
                total_reg <= total_reg + elem_ext;
            end
            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.set_best_full)
            begin
                best_reg <= pos_reg + LEN_W'(1);
            end
            if (cmd.take_cand && (cand > best_reg))
            begin
                best_reg <= cand;
            end
            if (cmd.pos_inc)
            begin
                pos_reg <= pos_reg + LEN_W'(1);
            end
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            end
            if (cmd.clear_run)
            begin
                total_reg   <= '0;
                pos_reg     <= '0;
                best_reg    <= '0;
                ovf_reg     <= 1'b0;
                epoch_reg   <= epoch_reg + EW'(1);
                clr_cnt_reg <= '0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            elem_reg <= elem_in;
        end
        if (cmd.mod_start)
        begin
            key_reg <= key_in;
        end
        if (cmd.probe_init)
        begin
            idx_reg <= home;
            cnt_reg <= '0;
        end
        else if (cmd.probe_next)
        begin
            idx_reg <= (idx_reg == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : idx_reg + SLOT_W'(1);
            cnt_reg <= cnt_reg + SLOT_W'(1);
        end
        if (cmd.load_out)
        begin
            out_len_reg <= best_reg;
            out_ovf_reg <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_len   = out_len_reg;
    assign out_ovf   = out_ovf_reg;

    a_wr_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> !slot_live)
        else $error("insert overwrites a live table slot");

    a_load_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> last_reg)
        else $error("result loaded for an item not marked last");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LEN_W'(MAX_LEN))
        else $error("element position beyond capacity");

    a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, best_reg} <= ({1'b0, pos_reg} + (LEN_W + 1)'(1))))
        else $error("best length exceeds elements seen");

endmodule

// ===== hdl/lswsum_ctrl.sv =====
// Controller: sequences sum update, hash lookup, insert, result and table clearing.
module lswsum_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output lswsum_pkg::lswsum_cmd_t cmd,
    input  lswsum_pkg::lswsum_sts_t sts
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_LOOK  = 3'd3;
    localparam logic [2:0] ST_MODW  = 3'd4;
    localparam logic [2:0] ST_RD    = 3'd5;
    localparam logic [2:0] ST_CHK   = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       mode_reg;
    logic       mode_next;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (sts.cap_full)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = ST_FIN;
                end
                else
                begin
                    cmd.add    = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.mod_start = 1'b1;
                state_next    = ST_MODW;
                if (sts.eq_target)
                begin
                    cmd.set_best_full = 1'b1;
                    mode_next         = MODE_INSERT;
                end
                else if (sts.diff_ok)
                begin
                    cmd.key_diff = 1'b1;
                    mode_next    = MODE_LOOKUP;
                end
                else
                begin
                    mode_next = MODE_INSERT;
                end
            end
            ST_MODW:
            begin
                if (sts.mod_done)
                begin
                    cmd.probe_init = 1'b1;
                    state_next     = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (sts.slot_hit || sts.slot_free || sts.probe_last)
                begin
                    if (mode_reg == MODE_LOOKUP)
                    begin
                        cmd.take_cand = sts.slot_hit;
                        cmd.mod_start = 1'b1;
                        mode_next     = MODE_INSERT;
                        state_next    = ST_MODW;
                    end
                    else
                    begin
                        cmd.mem_wr  = sts.slot_free;
                        cmd.pos_inc = 1'b1;
                        state_next  = ST_FIN;
                    end
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_RD;
                end
            end
            ST_FIN:
            begin
                if (!sts.last_item)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.clear_run = 1'b1;
                    state_next    = sts.epoch_wrap ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            mode_reg  <= MODE_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHK) |-> ($past(state_reg) == ST_RD))
        else $error("slot checked without a preceding read");

    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("item accepted during clearing pass");

    a_wr_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> (mode_reg == MODE_INSERT))
        else $error("table write during lookup probe");

endmodule

// ===== hdl/longest_subarray_with_sum.sv =====
// Top level of the longest-subarray-with-given-sum block.
//
// Takes one signed element per s_ transaction and keeps a running 27-bit prefix sum plus a
// linear-probing hash table (prefix sum -> first position) in a single-port RAM. On the element
// with s_tlast set, one m_ transaction carries the length of the longest contiguous run that sums
// to target_sum (0 if none) and, in m_tuser, a flag that the array held more than MAX_LEN
// elements; extra elements are dropped. Each element is added to the prefix sum, then a lookup
// of (prefix - target) probes the table when one is needed, then an insert probe of the prefix
// runs; a dropped element skips both probes. Each probe step is a RAM read plus a compare on
// the one table port. With a non-power-of-two TABLE_SLOTS each home-slot computation is a
// reciprocal multiply, then multiply back and subtract, instead of a mask. Table entries carry
// an 8-bit run epoch, so ending a run is instant; after reset and after every 256th run the
// block sweeps every table slot with s_tready low. The result sits in an output register,
// so a new array can start while it waits. Write target_sum through cfg_wr_en/cfg_wr_data
// only while the block is idle.
module longest_subarray_with_sum #(
    parameter int MAX_LEN     = lswsum_pkg::DEF_MAX_LEN,
    parameter int VALUE_BITS  = lswsum_pkg::DEF_VALUE_BITS,
    parameter int TABLE_SLOTS = lswsum_pkg::DEF_TABLE_SLOTS,
    localparam int LEN_W  = $clog2(MAX_LEN + 1),
    localparam int IN_W   = ((VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_W  = ((LEN_W + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // target_sum register write
    input  logic                            cfg_wr_en,
    input  logic [lswsum_pkg::SUM_BITS-1:0] cfg_wr_data,
    // element stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_W-1:0]                 s_tdata,   // element_value
    input  logic                            s_tlast,   // is_last
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_W-1:0]                m_tdata,   // longest_length
    output logic                            m_tuser    // overflow_flag
);

    lswsum_pkg::lswsum_cmd_t cmd;
    lswsum_pkg::lswsum_sts_t sts;
    logic [LEN_W-1:0]        out_len;

    // controller walks each element through add, lookup probe, insert probe, finish
    lswsum_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath holds the run state, the table RAM and the result register
    lswsum_dp #(
        .MAX_LEN     (MAX_LEN),
        .VALUE_BITS  (VALUE_BITS),
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .elem_in     (s_tdata[VALUE_BITS-1:0]),
        .last_in     (s_tlast),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (m_tvalid),
        .out_len     (out_len),
        .out_ovf     (m_tuser)
    );

    // zero-pad the length to whole bytes
    assign m_tdata = OUT_W'(out_len);

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for longest_subarray_with_sum: streams arrays and predicts each run.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_BITS = lswsum_pkg::SUM_BITS;
    localparam int MAX_LEN  = lswsum_pkg::DEF_MAX_LEN;
    localparam int ELEM_W   = lswsum_pkg::DEF_VALUE_BITS;
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int IN_W     = ((ELEM_W + 7) / 8) * 8;
    localparam int OUT_W    = ((LEN_W + 7) / 8) * 8;

    // Stop the random part once the element goal is met; the array past capacity alone
    // carries most of it.
    localparam int ITEM_GOAL     = 1150;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 600;
    localparam int BURST_MAX     = 18;
    localparam longint LIMIT_NS  = 20_000_000;

    // Keys live in a 27-bit signed space; a difference outside it can never be stored.
    localparam longint KEY_LIM = 64'sd1 << (SUM_BITS - 1);

    typedef logic signed [SUM_BITS-1:0] sum_t;
    typedef logic signed [ELEM_W-1:0]   elem_t;

    typedef struct {
        logic [LEN_W-1:0] length;
        logic             overflow;
    } run_result_t;

    typedef enum int { ELEM_SMALL, ELEM_FULL, ELEM_CLUSTER, ELEM_EDGE } elem_mode_t;

    // Tracks the prefix sums of the current array and the first position of each one,
    // and holds the run lengths still owed by the block.
    class subarray_tracker;
        sum_t          target;
        sum_t          prefix;
        int unsigned   position;
        int unsigned   best;
        bit            overflowed;
        int unsigned   first_pos[longint];
        run_result_t   owed_lengths[$];
        int            errors;
        int            results;
        int            elements;
        int            over_runs;

        function new();
            target = '0;
            clear_run();
        endfunction

        function void clear_run();
            prefix     = '0;
            position   = 0;
            best       = 0;
            overflowed = 1'b0;
            first_pos.delete();
        endfunction

        function void take_element(elem_t value, bit last);
            longint      gap;
            run_result_t owed;
            elements++;
            if (position < MAX_LEN)
            begin
                prefix = prefix + value;   // wraps at the sum width
                gap = longint'(prefix) - longint'(target);
                if (prefix == target)
                    best = position + 1;
                else if (gap >= -KEY_LIM && gap < KEY_LIM && first_pos.exists(gap))
                begin
                    if (position - first_pos[gap] > best)
                        best = position - first_pos[gap];
                end
                // At most MAX_LEN inserts per array, so the table never runs out of slots.
                if (!first_pos.exists(longint'(prefix)))
                    first_pos[longint'(prefix)] = position;
                position++;
            end
            else
                overflowed = 1'b1;
            if (last)
            begin
                owed.length   = LEN_W'(best);
                owed.overflow = overflowed;
                if (overflowed)
                    over_runs++;
                owed_lengths.push_back(owed);
                clear_run();
            end
        endfunction

        function void check_length(logic [LEN_W-1:0] length, logic overflow);
            run_result_t want;
            results++;
            if (owed_lengths.size() == 0)
            begin
                $error("unexpected result: longest_length=%0d overflow_flag=%0b",
                       length, overflow);
                errors++;
                return;
            end
            want = owed_lengths.pop_front();
            if (length !== want.length)
            begin
                $error("longest_length: expected %0d, actual %0d", want.length, length);
                errors++;
            end
            if (overflow !== want.overflow)
            begin
                $error("overflow_flag: expected %0b, actual %0b", want.overflow, overflow);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [SUM_BITS-1:0] cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;    // element_value
    logic                s_tlast;    // is_last
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;    // longest_length
    logic                m_tuser;    // overflow_flag

    subarray_tracker tracker;
    bit              send_idle;
    bit              recv_idle;
    bit              hold_request;
    int              target_writes;

    longest_subarray_with_sum DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Sample both handshakes on the pre-edge values. Check the output first so that a
    // result can never be matched against an array that completes on the same edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (m_tvalid && m_tready)
                tracker.check_length(m_tdata[LEN_W-1:0], m_tuser);
            if (s_tvalid && s_tready)
                tracker.take_element($signed(s_tdata[ELEM_W-1:0]), s_tlast);
        end
    end

    // Result sink: pick m_tready after each edge with a nonblocking assignment. A hold request starves the output
    // for a long stretch; otherwise stall in random bursts when idling is enabled.
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (recv_idle && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, BURST_MAX) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Offer one element and hold it until accepted; optionally idle first, with junk on
    // the data lines to show that nothing is taken while tvalid is low.
    task automatic push_element(elem_t value, bit last);
        logic [IN_W-1:0] word;
        word = '0;
        word[ELEM_W-1:0] = value;
        if (send_idle && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_W'($urandom);
            s_tlast  <= 1'($urandom);
            repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= last;
        do @(posedge clk); while (s_tready !== 1'b1);
    endtask

    function automatic elem_t pick_element(elem_mode_t mode);
        case (mode)
            ELEM_SMALL:   return elem_t'(int'($urandom_range(0, 8)) - 4);
            ELEM_FULL:    return elem_t'($urandom);
            // multiples of the table size all land on the same home slot
            ELEM_CLUSTER: return elem_t'((int'($urandom_range(0, 6)) - 3) * 2048);
            default:
                case ($urandom_range(0, 4))
                    0:       return elem_t'(32767);
                    1:       return elem_t'(-32768);
                    2:       return elem_t'(1);
                    3:       return elem_t'(-1);
                    default: return elem_t'(0);
                endcase
        endcase
    endfunction

    function automatic elem_mode_t pick_mode();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return ELEM_SMALL;
        if (roll < 70)
            return ELEM_FULL;
        if (roll < 85)
            return ELEM_CLUSTER;
        return ELEM_EDGE;
    endfunction

    // Mostly short arrays; collision-heavy arrays stay short so probe chains stay cheap.
    function automatic int pick_length(elem_mode_t mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return $urandom_range(1, 3);
        if (roll < 93 || mode == ELEM_CLUSTER)
            return $urandom_range(4, 16);
        return $urandom_range(17, 60);
    endfunction

    function automatic sum_t pick_target();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return sum_t'(int'($urandom_range(0, 12)) - 6);
        if (roll < 55)
            return sum_t'((int'($urandom_range(0, 8)) - 4) * 2048);
        if (roll < 80)
            return sum_t'(int'($urandom_range(0, 2097152)) - 1048576);
        if (roll < 90)
            return {1'b1, {(SUM_BITS - 1){1'b0}}};
        return {1'b0, {(SUM_BITS - 1){1'b1}}};
    endfunction

    task automatic push_array(int len, elem_mode_t mode);
        for (int i = 0; i < len; i++)
            push_element(pick_element(mode), i == len - 1);
    endtask

    // Write target_sum; only called with no element in flight and nothing owed (a table sweep may still run).
    task automatic write_target(sum_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.target = value;
        target_writes++;
    endtask

    // Drop tvalid, wait for every owed result, then give the block time to finish up.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.owed_lengths.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int phase;
        int item_base;
        int arrays_in_phase;
        elem_mode_t mode;
        tracker = new();
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        send_idle    = 1'b0;
        recv_idle    = 1'b0;
        hold_request = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero target. Lone element with no match, the element extremes with
        // the whole prefix matching, a chain of keys sharing one home slot, a lone zero.
        write_target(sum_t'(0));
        push_element(elem_t'(5), 1'b1);
        push_element(elem_t'(32767), 1'b0);
        push_element(elem_t'(-32768), 1'b0);
        push_element(elem_t'(1), 1'b0);
        push_element(elem_t'(7), 1'b1);
        push_element(elem_t'(2048), 1'b0);
        push_element(elem_t'(2048), 1'b0);
        push_element(elem_t'(-4096), 1'b0);
        push_element(elem_t'(2048), 1'b0);
        push_element(elem_t'(4096), 1'b0);
        push_element(elem_t'(-6144), 1'b1);
        push_element(elem_t'(0), 1'b1);
        settle();

        // Extreme targets: prefix minus target can fall outside the key range.
        write_target({1'b1, {(SUM_BITS - 1){1'b0}}});
        push_element(elem_t'(100), 1'b0);
        push_element(elem_t'(-200), 1'b0);
        push_element(elem_t'(32767), 1'b1);
        settle();
        write_target({1'b0, {(SUM_BITS - 1){1'b1}}});
        push_element(elem_t'(-32768), 1'b0);
        push_element(elem_t'(-5), 1'b0);
        push_element(elem_t'(9), 1'b1);
        settle();

        // Small target: a longer run found through a stored prefix, not from the start.
        write_target(sum_t'(3));
        push_element(elem_t'(5), 1'b0);
        push_element(elem_t'(1), 1'b0);
        push_element(elem_t'(2), 1'b0);
        push_element(elem_t'(0), 1'b1);
        settle();

        // Random phases, each with a fresh target and its own idling mix.
        phase     = 0;
        item_base = tracker.elements;
        while (tracker.elements - item_base < ITEM_GOAL)
        begin
            write_target(pick_target());
            send_idle = 1'($urandom);
            recv_idle = 1'($urandom);
            if (phase == 0)
            begin
                // Starve the output while short arrays keep coming, so the block backs up
                // and holds s_tready low.
                send_idle    = 1'b0;
                hold_request = 1'b1;
                for (int i = 0; i < 40; i++)
                    push_array($urandom_range(1, 2), ELEM_SMALL);
            end
            else
            begin
                // One array past capacity early on; the array after it must start clean.
                if (phase == 1)
                    push_array($urandom_range(MAX_LEN + 1, MAX_LEN + 6), ELEM_SMALL);
                arrays_in_phase = $urandom_range(5, 30);
                for (int i = 0; i < arrays_in_phase; i++)
                begin
                    mode = pick_mode();
                    push_array(pick_length(mode), mode);
                end
            end
            settle();
            phase++;
        end

        // Tail: no idling on either side.
        write_target(pick_target());
        send_idle = 1'b0;
        recv_idle = 1'b0;
        for (int i = 0; i < 10; i++)
        begin
            mode = pick_mode();
            push_array(pick_length(mode), mode);
        end
        settle();

        $display("covered %0d elements in %0d arrays, %0d of them past capacity",
                 tracker.elements, tracker.results, tracker.over_runs);
        $display("%0d target settings over %0d random phases, one output hold of %0d cycles",
                 target_writes, phase, HOLD_CYCLES);
        if (tracker.errors == 0)
            $display("longest_subarray_with_sum: match");
        else
            $display("longest_subarray_with_sum: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("time limit reached with %0d results still owed",
                 tracker.owed_lengths.size());
        $display("longest_subarray_with_sum: mismatch");
        $finish;
    end

endmodule
